/* src/mvrm_pkg.sv */
// shared types, constants and codes for the voice mixer
package mvrm_pkg;

   // voice table and sample memory geometry
   localparam int MAX_VOICES = 64;
   localparam int VIDX_W     = $clog2(MAX_VOICES);
   localparam int CNT_W      = $clog2(MAX_VOICES + 1);
   localparam int SAMPLE_AW  = 16;

   // fade arithmetic, Q1.16
   localparam logic [16:0] FADE_ONE  = 17'h10000;
   localparam logic [16:0] FADE_STEP = 17'd328;
   localparam logic [16:0] CURSOR_MAX = 17'h1FFFF;

   // fade direction codes
   localparam logic [1:0] DIR_HOLD = 2'd0;
   localparam logic [1:0] DIR_UP   = 2'd1;
   localparam logic [1:0] DIR_DOWN = 2'd2;

   // operation codes
   localparam logic [2:0] FUNC_WRITE   = 3'd0;
   localparam logic [2:0] FUNC_START   = 3'd1;
   localparam logic [2:0] FUNC_FADEOUT = 3'd2;
   localparam logic [2:0] FUNC_FRAME   = 3'd3;
   localparam logic [2:0] FUNC_MIX     = 3'd4;

   // register indexes
   localparam logic [0:0] CSR_MASTER_VOLUME = 1'd0;
   localparam logic [0:0] CSR_MIX_PAUSED    = 1'd1;
   localparam logic [15:0] MASTER_VOLUME_RESET = 16'd16384;

   // one voice table entry
   typedef struct packed {
      logic [15:0] base;
      logic [16:0] len;
      logic [16:0] cursor;
      logic [15:0] frac;
      logic [17:0] step;
      logic [16:0] fade;
      logic [1:0]  dir;
   } voice_type;

   // stage enables of the interpolation lane
   typedef struct packed {
      logic m1;
      logic m2;
      logic m3;
   } lane_ctl_type;

endpackage

/* src/multi_voice_resampling_mixer.sv */
// stereo voice mixer with sample memory, voice table and op sequencer
//
// Usage: one op item enters on req_ (func selects write sample, start voice,
// fade out all, frame update or mix) and exactly one item leaves on rsp_.
// csr_ writes master_volume (index 0) and mix_paused (index 1); csr_ready is
// always high; the user must make writes only while the block is idle, and
// the block itself does not enforce this.
// The single read port of the voice table and of the sample memory sets the
// pace: each voice entry is read, its two neighbouring sample words
// fetched in turn, then scaled through a three-stage multiply lane per side.
// One op is worked at a time; the next item can be taken in the cycle that
// rsp_valid rises, even while the previous result still waits in the output
// register. If rsp_ready stays low, a finished op waits until it frees.
// Reset empties the voice table (count zero), restores master volume 0.25 and
// unpauses; the sample memory and voice entries are undefined until written.
module multi_voice_resampling_mixer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          req_func,
   input  logic [15:0]         req_addr,
   input  logic signed [15:0]  req_in_left,
   input  logic signed [15:0]  req_in_right,
   input  logic [16:0]         req_voice_length,
   input  logic [17:0]         req_rate_step,
   input  logic                req_fade_in,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [15:0]  rsp_mix_left,
   output logic signed [15:0]  rsp_mix_right,
   output logic [6:0]          rsp_voices_active,
   output logic                rsp_status,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [0:0]          csr_index,
   input  logic [15:0]         csr_wdata
);

   localparam int VW = mvrm_pkg::VIDX_W;
   localparam int CW = mvrm_pkg::CNT_W;

   // sequencer states
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_FIN    = 4'd1;
   localparam logic [3:0] ST_FO_RD  = 4'd2;
   localparam logic [3:0] ST_FO_WR  = 4'd3;
   localparam logic [3:0] ST_FR_RD  = 4'd4;
   localparam logic [3:0] ST_FR_EV  = 4'd5;
   localparam logic [3:0] ST_FR_CP  = 4'd6;
   localparam logic [3:0] ST_MX_RD  = 4'd7;
   localparam logic [3:0] ST_MX_S0  = 4'd8;
   localparam logic [3:0] ST_MX_S1  = 4'd9;
   localparam logic [3:0] ST_MX_M1  = 4'd10;
   localparam logic [3:0] ST_MX_M2  = 4'd11;
   localparam logic [3:0] ST_MX_M3  = 4'd12;
   localparam logic [3:0] ST_MX_ACC = 4'd13;

   // memories
   mvrm_pkg::voice_type vmem [mvrm_pkg::MAX_VOICES];
   logic [31:0]         smem [2**mvrm_pkg::SAMPLE_AW];

   logic                vmem_we;
   logic [VW-1:0]       vmem_waddr;
   mvrm_pkg::voice_type vmem_wdata;
   logic [VW-1:0]       vmem_raddr;
   mvrm_pkg::voice_type vmem_rdata_ff;

   logic                          smem_we;
   logic [mvrm_pkg::SAMPLE_AW-1:0] smem_waddr;
   logic [31:0]                   smem_wdata;
   logic [mvrm_pkg::SAMPLE_AW-1:0] smem_raddr;
   logic [31:0]                   smem_rdata_ff;

   // control and working registers
   logic [3:0]          state_ff, state_in;
   logic [VW-1:0]       idx_ff, idx_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [15:0]         acc_l_ff, acc_l_in;
   logic [15:0]         acc_r_ff, acc_r_in;
   logic                status_ff, status_in;
   mvrm_pkg::voice_type voice_ff, voice_in;
   logic [31:0]         w0_ff, w0_in;
   logic                nbok_ff, nbok_in;
   logic [15:0]         master_volume_ff;
   logic                mix_paused_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [15:0]         rsp_left_ff, rsp_right_ff;
   logic [CW-1:0]       rsp_count_ff;
   logic                rsp_status_ff;
   logic                rsp_load;

   // helpers
   logic [VW-1:0]       last_idx;
   logic                at_last;
   mvrm_pkg::voice_type upd;
   logic [17:0]         fsum;
   logic                retire;
   logic [18:0]         asum;
   logic [17:0]         ncur;
   logic [31:0]         w1;
   mvrm_pkg::lane_ctl_type lane_ctl;
   logic [15:0]         contrib_l, contrib_r;

   assign last_idx  = VW'(count_ff - 1'b1);
   assign at_last   = (idx_ff == last_idx);
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   // frame update of one entry: fade step and retire test
   always_comb begin
      upd  = vmem_rdata_ff;
      fsum = {1'b0, vmem_rdata_ff.fade} + {1'b0, mvrm_pkg::FADE_STEP};
      case (vmem_rdata_ff.dir)
         mvrm_pkg::DIR_UP: begin
            if (fsum > {1'b0, mvrm_pkg::FADE_ONE}) begin
               upd.fade = mvrm_pkg::FADE_ONE;
               upd.dir  = mvrm_pkg::DIR_HOLD;
            end else begin
               upd.fade = fsum[16:0];
            end
         end
         mvrm_pkg::DIR_DOWN: begin
            upd.fade = (vmem_rdata_ff.fade > mvrm_pkg::FADE_STEP) ?
                       vmem_rdata_ff.fade - mvrm_pkg::FADE_STEP : 17'd0;
         end
         default: begin
            upd.fade = vmem_rdata_ff.fade;
         end
      endcase
      retire = (vmem_rdata_ff.cursor >= vmem_rdata_ff.len) || (upd.fade == 17'd0);
   end

   // cursor advance of the voice being mixed
   assign asum = {3'b000, voice_ff.frac} + {1'b0, voice_ff.step};
   assign ncur = {1'b0, voice_ff.cursor} + {15'd0, asum[18:16]};

   // second neighbour is zero past the end
   assign w1 = nbok_ff ? smem_rdata_ff : 32'd0;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      count_in   = count_ff;
      acc_l_in   = acc_l_ff;
      acc_r_in   = acc_r_ff;
      status_in  = status_ff;
      voice_in   = voice_ff;
      w0_in      = w0_ff;
      nbok_in    = nbok_ff;
      vmem_we    = 1'b0;
      vmem_waddr = idx_ff;
      vmem_wdata = vmem_rdata_ff;
      vmem_raddr = idx_ff;
      smem_we    = 1'b0;
      smem_waddr = req_addr;
      smem_wdata = {req_in_right, req_in_left};
      smem_raddr = voice_ff.base + voice_ff.cursor[15:0];
      lane_ctl   = '0;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               acc_l_in  = 16'd0;
               acc_r_in  = 16'd0;
               status_in = 1'b0;
               state_in  = ST_FIN;
               case (req_func)
                  mvrm_pkg::FUNC_WRITE: begin
                     smem_we = 1'b1;
                  end
                  mvrm_pkg::FUNC_START: begin
                     if (count_ff >= CW'(mvrm_pkg::MAX_VOICES)) begin
                        status_in = 1'b1;
                     end else begin
                        vmem_we           = 1'b1;
                        vmem_waddr        = VW'(count_ff);
                        vmem_wdata.base   = req_addr;
                        vmem_wdata.len    = req_voice_length;
                        vmem_wdata.cursor = 17'd0;
                        vmem_wdata.frac   = 16'd0;
                        vmem_wdata.step   = req_rate_step;
                        vmem_wdata.fade   = req_fade_in ? 17'd0 : mvrm_pkg::FADE_ONE;
                        vmem_wdata.dir    = req_fade_in ? mvrm_pkg::DIR_UP :
                                                          mvrm_pkg::DIR_HOLD;
                        count_in          = count_ff + 1'b1;
                     end
                  end
                  mvrm_pkg::FUNC_FADEOUT: begin
                     if (count_ff != '0) begin
                        idx_in   = '0;
                        state_in = ST_FO_RD;
                     end
                  end
                  mvrm_pkg::FUNC_FRAME: begin
                     if (count_ff != '0) begin
                        idx_in   = last_idx;
                        state_in = ST_FR_RD;
                     end
                  end
                  mvrm_pkg::FUNC_MIX: begin
                     if (!mix_paused_ff && count_ff != '0) begin
                        idx_in   = '0;
                        state_in = ST_MX_RD;
                     end
                  end
                  default: begin
                     state_in = ST_FIN;
                  end
               endcase
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         // fade out all: read then write back each entry
         ST_FO_RD: begin
            state_in = ST_FO_WR;
         end
         ST_FO_WR: begin
            vmem_we        = 1'b1;
            vmem_wdata.dir = mvrm_pkg::DIR_DOWN;
            if (at_last) begin
               state_in = ST_FIN;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_FO_RD;
            end
         end
         // frame update, from the last entry down
         ST_FR_RD: begin
            state_in = ST_FR_EV;
         end
         ST_FR_EV: begin
            if (retire && !at_last) begin
               vmem_raddr = last_idx;
               state_in   = ST_FR_CP;
            end else begin
               if (retire) begin
                  count_in = count_ff - 1'b1;
               end else begin
                  vmem_we    = 1'b1;
                  vmem_wdata = upd;
               end
               if (idx_ff == '0) begin
                  state_in = ST_FIN;
               end else begin
                  idx_in   = idx_ff - 1'b1;
                  state_in = ST_FR_RD;
               end
            end
         end
         ST_FR_CP: begin
            vmem_we  = 1'b1;
            count_in = count_ff - 1'b1;
            if (idx_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               idx_in   = idx_ff - 1'b1;
               state_in = ST_FR_RD;
            end
         end
         // mix: voice entry, two sample words, three lane stages
         ST_MX_RD: begin
            state_in = ST_MX_S0;
         end
         ST_MX_S0: begin
            voice_in   = vmem_rdata_ff;
            smem_raddr = vmem_rdata_ff.base + vmem_rdata_ff.cursor[15:0];
            if (vmem_rdata_ff.cursor >= vmem_rdata_ff.len) begin
               if (at_last) begin
                  state_in = ST_FIN;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_MX_RD;
               end
            end else begin
               state_in = ST_MX_S1;
            end
         end
         ST_MX_S1: begin
            smem_raddr        = voice_ff.base + voice_ff.cursor[15:0] + 16'd1;
            nbok_in           = ({1'b0, voice_ff.cursor} + 18'd1) < {1'b0, voice_ff.len};
            w0_in             = smem_rdata_ff;
            vmem_we           = 1'b1;
            vmem_wdata        = voice_ff;
            vmem_wdata.cursor = ncur[17] ? mvrm_pkg::CURSOR_MAX : ncur[16:0];
            vmem_wdata.frac   = asum[15:0];
            state_in          = ST_MX_M1;
         end
         ST_MX_M1: begin
            lane_ctl.m1 = 1'b1;
            state_in    = ST_MX_M2;
         end
         ST_MX_M2: begin
            lane_ctl.m2 = 1'b1;
            state_in    = ST_MX_M3;
         end
         ST_MX_M3: begin
            lane_ctl.m3 = 1'b1;
            state_in    = ST_MX_ACC;
         end
         ST_MX_ACC: begin
            acc_l_in = acc_l_ff + contrib_l;
            acc_r_in = acc_r_ff + contrib_r;
            if (at_last) begin
               state_in = ST_FIN;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_MX_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register handshake
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // voice table memory
   always_ff @(posedge clock) begin
      if (vmem_we) begin
         vmem[vmem_waddr] <= vmem_wdata;
      end
      vmem_rdata_ff <= vmem[vmem_raddr];
   end

   // sample memory
   always_ff @(posedge clock) begin
      if (smem_we) begin
         smem[smem_waddr] <= smem_wdata;
      end
      smem_rdata_ff <= smem[smem_raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         count_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
         master_volume_ff <= mvrm_pkg::MASTER_VOLUME_RESET;
         mix_paused_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_index == mvrm_pkg::CSR_MASTER_VOLUME) begin
            master_volume_ff <= csr_wdata;
         end
         if (csr_valid && csr_index == mvrm_pkg::CSR_MIX_PAUSED) begin
            mix_paused_ff <= csr_wdata[0];
         end
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      acc_l_ff  <= acc_l_in;
      acc_r_ff  <= acc_r_in;
      status_ff <= status_in;
      voice_ff  <= voice_in;
      w0_ff     <= w0_in;
      nbok_ff   <= nbok_in;
      if (rsp_load) begin
         rsp_left_ff   <= acc_l_ff;
         rsp_right_ff  <= acc_r_ff;
         rsp_count_ff  <= count_ff;
         rsp_status_ff <= status_ff;
      end
   end

   // left and right interpolation lanes
   mvrm_lane u_lane_l (
      .clock   (clock),
      .ctl     (lane_ctl),
      .s0      ($signed(w0_ff[15:0])),
      .s1      ($signed(w1[15:0])),
      .frac    (voice_ff.frac),
      .vol     (master_volume_ff),
      .fade    (voice_ff.fade),
      .contrib (contrib_l)
   );

   mvrm_lane u_lane_r (
      .clock   (clock),
      .ctl     (lane_ctl),
      .s0      ($signed(w0_ff[31:16])),
      .s1      ($signed(w1[31:16])),
      .frac    (voice_ff.frac),
      .vol     (master_volume_ff),
      .fade    (voice_ff.fade),
      .contrib (contrib_r)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mix_left      = $signed(rsp_left_ff);
   assign rsp_mix_right     = $signed(rsp_right_ff);
   assign rsp_voices_active = 7'(rsp_count_ff);
   assign rsp_status        = rsp_status_ff;

   // voice count never passes the table size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(mvrm_pkg::MAX_VOICES))
      else $error("voice count beyond table size");

   // a finished op with a free output register is presented next cycle
   a_fin_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("finished op not presented");

   // a start into a table with room adds exactly one voice
   a_start_count: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_func == mvrm_pkg::FUNC_START &&
       count_ff < CW'(mvrm_pkg::MAX_VOICES)) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("start did not add a voice");

   // a frame update never grows the table
   a_frame_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FR_EV || state_ff == ST_FR_CP) |=> count_ff <= $past(count_ff))
      else $error("frame update grew the table");

endmodule

/* src/mvrm_lane.sv */
// one channel of interpolation, master gain and fade scaling
module mvrm_lane (
   input  logic                       clock,
   input  mvrm_pkg::lane_ctl_type     ctl,
   input  logic signed [15:0]         s0,
   input  logic signed [15:0]         s1,
   input  logic [15:0]                frac,
   input  logic [15:0]                vol,
   input  logic [16:0]                fade,
   output logic [15:0]                contrib
);

   logic signed [16:0] diff;
   logic signed [33:0] prod1;
   logic signed [33:0] t_in;
   logic signed [33:0] t_ff;
   logic signed [50:0] prod2;
   logic signed [50:0] bias2;
   logic signed [50:0] sum2;
   logic signed [17:0] v_ff;
   logic signed [35:0] prod3;
   logic signed [35:0] bias3;
   logic signed [35:0] sum3;
   logic [15:0]        contrib_ff;

   // s0*(1-frac) + s1*frac as s0*2^16 + (s1-s0)*frac
   assign diff  = $signed({s1[15], s1}) - $signed({s0[15], s0});
   assign prod1 = diff * $signed({1'b0, frac});
   assign t_in  = prod1 + $signed({{2{s0[15]}}, s0, 16'h0000});

   // master gain, divide by 2^32 toward zero
   assign prod2 = t_ff * $signed({1'b0, vol});
   assign bias2 = prod2[50] ? $signed(51'h0_FFFF_FFFF) : $signed(51'h0);
   assign sum2  = prod2 + bias2;

   // fade, divide by 2^16 toward zero
   assign prod3 = v_ff * $signed({1'b0, fade});
   assign bias3 = prod3[35] ? $signed(36'h0_FFFF) : $signed(36'h0);
   assign sum3  = prod3 + bias3;

   // pipeline registers
   always_ff @(posedge clock) begin
      if (ctl.m1) begin
         t_ff <= t_in;
      end
      if (ctl.m2) begin
         v_ff <= sum2[49:32];
      end
      if (ctl.m3) begin
         contrib_ff <= sum3[31:16];
      end
   end

   assign contrib = contrib_ff;

endmodule

/* sim/tb_top.sv */
// self-checking mixer testbench: directed, full-table, register and random op tests
module tb_top;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int ITEM_TARGET = 700;

   // one op item as driven on req_
   typedef struct {
      logic [2:0]  func;
      logic [15:0] addr;
      logic [15:0] left;
      logic [15:0] right;
      logic [16:0] len;
      logic [17:0] step;
      logic        fin;
   } op_item_type;

   // one predicted result item
   typedef struct {
      logic [15:0] mix_l;
      logic [15:0] mix_r;
      logic [6:0]  count;
      logic        status;
   } mix_result_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [2:0]         req_func;
   logic [15:0]        req_addr;
   logic signed [15:0] req_in_left;
   logic signed [15:0] req_in_right;
   logic [16:0]        req_voice_length;
   logic [17:0]        req_rate_step;
   logic               req_fade_in;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [15:0] rsp_mix_left;
   logic signed [15:0] rsp_mix_right;
   logic [6:0]         rsp_voices_active;
   logic               rsp_status;
   logic               csr_valid;
   logic               csr_ready;
   logic [0:0]         csr_index;
   logic [15:0]        csr_wdata;

   multi_voice_resampling_mixer u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_addr          (req_addr),
      .req_in_left       (req_in_left),
      .req_in_right      (req_in_right),
      .req_voice_length  (req_voice_length),
      .req_rate_step     (req_rate_step),
      .req_fade_in       (req_fade_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_mix_left      (rsp_mix_left),
      .rsp_mix_right     (rsp_mix_right),
      .rsp_voices_active (rsp_voices_active),
      .rsp_status        (rsp_status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // mixer state as the testbench sees it
   logic [31:0]         sample_mem [0:65535];
   bit                  word_written [0:65535];
   mvrm_pkg::voice_type voice_tab [0:mvrm_pkg::MAX_VOICES-1];
   int unsigned         n_voices;
   logic [15:0]         master_vol;
   bit                  paused;

   mix_result_type pending_results [$];
   int             mismatches = 0;
   int             burst_left;
   int             cycles = 0;
   int             items_sent;
   bit             stall_free;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // frame update: step fades, retire finished or silent voices from the top down
   function automatic void frame_step();
      int unsigned n;
      int unsigned i;
      int unsigned f;
      n = n_voices;
      while (n > 0) begin
         i = n - 1;
         if (voice_tab[i].dir == mvrm_pkg::DIR_UP) begin
            f = voice_tab[i].fade + mvrm_pkg::FADE_STEP;
            if (f > mvrm_pkg::FADE_ONE) begin
               f = mvrm_pkg::FADE_ONE;
               voice_tab[i].dir = mvrm_pkg::DIR_HOLD;
            end
            voice_tab[i].fade = f[16:0];
         end else if (voice_tab[i].dir == mvrm_pkg::DIR_DOWN) begin
            f = voice_tab[i].fade;
            voice_tab[i].fade = (f > mvrm_pkg::FADE_STEP) ?
                                17'(f - mvrm_pkg::FADE_STEP) : 17'd0;
         end
         if (voice_tab[i].cursor >= voice_tab[i].len || voice_tab[i].fade == 0) begin
            voice_tab[i] = voice_tab[n_voices - 1];
            n_voices--;
         end
         n--;
      end
   endfunction

   // scale one interpolated side by master volume and fade
   function automatic longint scale_side(logic [15:0] s0, logic [15:0] s1,
                                         longint a0, longint a1, logic [16:0] fade);
      longint t;
      longint v;
      t = longint'($signed(s0)) * a0 + longint'($signed(s1)) * a1;
      v = (t * longint'(master_vol)) / (longint'(1) <<< 32);
      v = (v * longint'(fade)) / 65536;
      return v;
   endfunction

   // mix one output sample and advance the playing voices
   function automatic void mix_sample(ref mix_result_type r);
      logic [31:0] acc_l;
      logic [31:0] acc_r;
      logic [31:0] w0;
      logic [31:0] w1;
      longint      a0;
      longint      a1;
      longint      v;
      int unsigned cur;
      int unsigned sum;
      acc_l = '0;
      acc_r = '0;
      if (paused)
         return;
      for (int i = 0; i < n_voices; i++) begin
         cur = voice_tab[i].cursor;
         if (cur >= voice_tab[i].len)
            continue;
         w0 = sample_mem[16'(voice_tab[i].base + cur)];
         w1 = '0;
         if (cur + 1 < voice_tab[i].len)
            w1 = sample_mem[16'(voice_tab[i].base + cur + 1)];
         a1 = longint'(voice_tab[i].frac);
         a0 = 65536 - a1;
         v = scale_side(w0[15:0], w1[15:0], a0, a1, voice_tab[i].fade);
         acc_l += v[31:0];
         v = scale_side(w0[31:16], w1[31:16], a0, a1, voice_tab[i].fade);
         acc_r += v[31:0];
         sum = voice_tab[i].frac + voice_tab[i].step;
         cur += sum >> 16;
         voice_tab[i].cursor = (cur > mvrm_pkg::CURSOR_MAX) ? mvrm_pkg::CURSOR_MAX :
                                                              cur[16:0];
         voice_tab[i].frac = sum[15:0];
      end
      r.mix_l = acc_l[15:0];
      r.mix_r = acc_r[15:0];
   endfunction

   // apply one op to the mixer state and give the result it should produce
   function automatic mix_result_type mixer_apply(op_item_type op);
      mix_result_type r;
      r = '{16'd0, 16'd0, 7'd0, 1'b0};
      case (op.func)
         mvrm_pkg::FUNC_WRITE: begin
            sample_mem[op.addr] = {op.right, op.left};
            word_written[op.addr] = 1'b1;
         end
         mvrm_pkg::FUNC_START: begin
            if (n_voices >= mvrm_pkg::MAX_VOICES) begin
               r.status = 1'b1;
            end else begin
               voice_tab[n_voices] = '{base: op.addr, len: op.len, cursor: 17'd0,
                                       frac: 16'd0, step: op.step,
                                       fade: op.fin ? 17'd0 : mvrm_pkg::FADE_ONE,
                                       dir: op.fin ? mvrm_pkg::DIR_UP :
                                                     mvrm_pkg::DIR_HOLD};
               n_voices++;
            end
         end
         mvrm_pkg::FUNC_FADEOUT: begin
            for (int i = 0; i < n_voices; i++)
               voice_tab[i].dir = mvrm_pkg::DIR_DOWN;
         end
         mvrm_pkg::FUNC_FRAME: frame_step();
         mvrm_pkg::FUNC_MIX:   mix_sample(r);
         default: ;
      endcase
      r.count = n_voices[6:0];
      return r;
   endfunction

   // address of a sample word the next mix would read without it being written
   function automatic bit unwritten_read(output logic [15:0] a);
      int unsigned cur;
      if (paused)
         return 1'b0;
      for (int i = 0; i < n_voices; i++) begin
         cur = voice_tab[i].cursor;
         if (cur >= voice_tab[i].len)
            continue;
         a = 16'(voice_tab[i].base + cur);
         if (!word_written[a])
            return 1'b1;
         a = 16'(voice_tab[i].base + cur + 1);
         if (cur + 1 < voice_tab[i].len && !word_written[a])
            return 1'b1;
      end
      return 1'b0;
   endfunction

   // send one item, with bursts and gaps on the sender side
   task automatic send_item(op_item_type op);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_func         <= op.func;
      req_addr         <= op.addr;
      req_in_left      <= op.left;
      req_in_right     <= op.right;
      req_voice_length <= op.len;
      req_rate_step    <= op.step;
      req_fade_in      <= op.fin;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      pending_results.push_back(mixer_apply(op));
   endtask

   function automatic op_item_type make_op(logic [2:0] func);
      op_item_type op;
      op = '{func, 16'd0, 16'd0, 16'd0, 17'd0, 18'd0, 1'b0};
      return op;
   endfunction

   task automatic write_word(logic [15:0] a, logic [15:0] l, logic [15:0] r);
      op_item_type op;
      op = make_op(mvrm_pkg::FUNC_WRITE);
      op.addr  = a;
      op.left  = l;
      op.right = r;
      send_item(op);
   endtask

   task automatic start_voice(logic [15:0] base, logic [16:0] len, logic [17:0] step,
                              logic fin);
      op_item_type op;
      op = make_op(mvrm_pkg::FUNC_START);
      op.addr = base;
      op.len  = len;
      op.step = step;
      op.fin  = fin;
      send_item(op);
   endtask

   // a mix item, preceded by writes of any word it would read unwritten
   task automatic mix_item();
      logic [15:0] a;
      while (unwritten_read(a))
         write_word(a, 16'($urandom), 16'($urandom));
      send_item(make_op(mvrm_pkg::FUNC_MIX));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [0:0] idx, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == mvrm_pkg::CSR_MASTER_VOLUME)
         master_vol = data;
      else
         paused = data[0];
   endtask

   // receiver stalls: runs of ready with random stall bursts, or none at all
   int stall_cnt;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_cnt <= 0;
      end else if (stall_free) begin
         rsp_ready <= 1'b1;
      end else if (stall_cnt > 0) begin
         rsp_ready <= 1'b0;
         stall_cnt <= stall_cnt - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 5) == 0)
            stall_cnt <= $urandom_range(1, 6);
      end
   end

   // compare each result item with the oldest prediction
   always @(posedge clock) begin
      mix_result_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result item: left %h right %h count %0d status %b",
                        rsp_mix_left, rsp_mix_right, rsp_voices_active, rsp_status);
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_mix_left !== exp_r.mix_l || rsp_mix_right !== exp_r.mix_r ||
                rsp_voices_active !== exp_r.count || rsp_status !== exp_r.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp l %h r %h n %0d st %b, got l %h r %h n %0d st %b",
                           exp_r.mix_l, exp_r.mix_r, exp_r.count, exp_r.status,
                           rsp_mix_left, rsp_mix_right, rsp_voices_active, rsp_status);
            end
         end
      end
   end

   // extremes of samples and voices, every op and the unknown codes
   task automatic test_directed();
      write_word(16'd0, 16'h7FFF, 16'h8000);
      write_word(16'd1, 16'h8000, 16'h7FFF);
      write_word(16'd2, 16'hFFFF, 16'h0001);
      write_word(16'hFFFF, 16'h1234, 16'hEDCB);
      start_voice(16'd0, 17'd3, 18'h08000, 1'b0);
      start_voice(16'hFFFF, 17'd2, 18'h3FFFF, 1'b0);
      start_voice(16'd0, 17'd0, 18'd0, 1'b1);
      start_voice(16'd2, 17'd1, 18'd0, 1'b1);
      start_voice(16'd0, 17'h10000, 18'h10000, 1'b0);
      repeat (3) mix_item();
      send_item(make_op(mvrm_pkg::FUNC_FRAME));
      mix_item();
      send_item(make_op(3'd5));
      send_item(make_op(3'd6));
      send_item(make_op(3'd7));
      send_item(make_op(mvrm_pkg::FUNC_FADEOUT));
      repeat (2) send_item(make_op(mvrm_pkg::FUNC_FRAME));
      mix_item();
   endtask

   // fill the table, start past full, then retire everything
   task automatic test_full_table();
      while (n_voices < mvrm_pkg::MAX_VOICES)
         start_voice(16'($urandom), 17'd0, 18'($urandom), 1'($urandom));
      start_voice(16'd0, 17'd2, 18'd1, 1'b0);
      start_voice(16'd5, 17'd9, 18'd7, 1'b1);
      mix_item();
      send_item(make_op(mvrm_pkg::FUNC_FRAME));
   endtask

   // register settings: volume extremes and paused mixing
   task automatic test_registers();
      logic [15:0] vols [4];
      vols = '{16'd0, 16'hFFFF, 16'd1, 16'h8000};
      foreach (vols[k]) begin
         wait_drained();
         csr_write(mvrm_pkg::CSR_MASTER_VOLUME, vols[k]);
         start_voice(16'd0, 17'd3, 18'h04000, 1'b0);
         repeat (3) mix_item();
      end
      wait_drained();
      csr_write(mvrm_pkg::CSR_MIX_PAUSED, 16'd1);
      repeat (3) mix_item();
      send_item(make_op(mvrm_pkg::FUNC_FRAME));
      wait_drained();
      csr_write(mvrm_pkg::CSR_MIX_PAUSED, 16'd0);
      csr_write(mvrm_pkg::CSR_MASTER_VOLUME, 16'd40000);
      repeat (2) mix_item();
   endtask

   // random op stream, mixes most often, over a changing set of voices
   task automatic test_random();
      int          sel;
      bit          half_done;
      bit          late_done;
      logic [15:0] base;
      logic [16:0] len;
      logic [17:0] step;
      half_done = 1'b0;
      late_done = 1'b0;
      while (items_sent < ITEM_TARGET) begin
         if (!half_done && items_sent >= ITEM_TARGET / 2) begin
            half_done = 1'b1;
            wait_drained();
            csr_write(mvrm_pkg::CSR_MASTER_VOLUME, 16'($urandom));
            stall_free = 1'b1;
         end else if (half_done && !late_done && items_sent >= ITEM_TARGET * 3 / 4) begin
            late_done  = 1'b1;
            stall_free = 1'b0;
         end
         sel = $urandom_range(0, 99);
         if (sel < 18) begin
            write_word(16'($urandom), 16'($urandom), 16'($urandom));
         end else if (sel < 34) begin
            case ($urandom_range(0, 2))
               0: base = 16'($urandom);
               1: base = 16'hFFF0 + 16'($urandom_range(0, 15));
               default: base = 16'($urandom_range(0, 200));
            endcase
            case ($urandom_range(0, 9))
               0: len = 17'd0;
               1: len = 17'h10000;
               2: len = 17'($urandom_range(0, 65536));
               default: len = 17'($urandom_range(1, 48));
            endcase
            case ($urandom_range(0, 9))
               0: step = 18'd0;
               1: step = 18'($urandom);
               default: step = 18'($urandom_range(1, 3 * 65536));
            endcase
            start_voice(base, len, step, 1'($urandom));
         end else if (sel < 38) begin
            send_item(make_op(mvrm_pkg::FUNC_FADEOUT));
         end else if (sel < 54) begin
            send_item(make_op(mvrm_pkg::FUNC_FRAME));
         end else if (sel < 96) begin
            mix_item();
         end else begin
            send_item(make_op(3'($urandom_range(5, 7))));
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_func         = '0;
      req_addr         = '0;
      req_in_left      = '0;
      req_in_right     = '0;
      req_voice_length = '0;
      req_rate_step    = '0;
      req_fade_in      = 1'b0;
      csr_valid        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      burst_left       = 0;
      items_sent       = 0;
      stall_free       = 1'b0;
      n_voices         = 0;
      master_vol       = mvrm_pkg::MASTER_VOLUME_RESET;
      paused           = 1'b0;
      foreach (word_written[k]) word_written[k] = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_full_table();
      test_registers();
      test_random();

      wait_drained();
      repeat (500) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
